>>> design/rrts_pkg.sv
`timescale 1ns / 1ps

package rrts_pkg;

   localparam int DEF_MAX_TASKS = 16;
   localparam logic [15:0] DEF_TIME_SLICE = 16'd500;

   localparam int OPCODE_W = 3;
   localparam int TASK_ID_W = 5;
   localparam int STATUS_W = 2;
   localparam int SLICE_W = 16;

   typedef enum logic [OPCODE_W-1:0] {
      OP_SPAWN   = 3'd0,
      OP_ISSUE   = 3'd1,
      OP_FINISH  = 3'd2,
      OP_QUERY   = 3'd3,
      OP_RESTART = 3'd4,
      OP_CLEAR   = 3'd5
   } opcode_type;

   localparam logic [STATUS_W-1:0] STATUS_RUNNING   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_COMPLETED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNKNOWN   = 2'd2;

   typedef struct packed {
      logic latch_req;
      logic scan_start;
      logic scan_step;
      logic execute;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_rotate;
      logic scan_hit;
      logic out_free;
   } dp_status_type;

endpackage

>>> design/rrts_if.sv
`timescale 1ns / 1ps

interface rrts_req_if;
   import rrts_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [OPCODE_W-1:0]  opcode;
   logic [TASK_ID_W-1:0] task_id;

   modport source (output valid, output opcode, output task_id, input ready);
   modport sink (input valid, input opcode, input task_id, output ready);
endinterface

interface rrts_rsp_if;
   import rrts_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [TASK_ID_W-1:0] granted_id;
   logic [STATUS_W-1:0]  task_status;
   logic                 all_done;
   logic                 table_full;

   modport source (output valid, output granted_id, output task_status,
                   output all_done, output table_full, input ready);
   modport sink (input valid, input granted_id, input task_status,
                 input all_done, input table_full, output ready);
endinterface

>>> design/rrts_ctrl.sv
`timescale 1ns / 1ps

module rrts_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  rrts_pkg::dp_status_type status,
   output rrts_pkg::ctrl_cmd_type  cmd
);
   import rrts_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_SCAN = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.need_rotate) begin
               cmd.scan_start = 1'b1;
               state_in = ST_SCAN;
            end else if (status.out_free) begin
               cmd.execute = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_hit) begin
               state_in = ST_EXEC;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> design/rrts_datapath.sv
`timescale 1ns / 1ps

module rrts_datapath #(
   parameter int MAX_TASKS = rrts_pkg::DEF_MAX_TASKS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  rrts_pkg::ctrl_cmd_type          cmd,
   output rrts_pkg::dp_status_type         status,
   input  logic [rrts_pkg::OPCODE_W-1:0]   req_opcode,
   input  logic [rrts_pkg::TASK_ID_W-1:0]  req_task_id,
   input  logic                            csr_write_enable,
   input  logic [rrts_pkg::SLICE_W-1:0]    csr_write_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [rrts_pkg::TASK_ID_W-1:0]  rsp_granted_id,
   output logic [rrts_pkg::STATUS_W-1:0]   rsp_task_status,
   output logic                            rsp_all_done,
   output logic                            rsp_table_full
);
   import rrts_pkg::*;

   localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CW = $clog2(MAX_TASKS + 1);
   localparam int IW = (CW > TASK_ID_W) ? CW : TASK_ID_W;

   logic [OPCODE_W-1:0]  op_ff;
   logic [TASK_ID_W-1:0] id_ff;
   logic [SLICE_W-1:0]   time_slice_ff;

   logic [MAX_TASKS-1:0] running_ff, running_in;
   logic [CW-1:0]        task_count_ff, task_count_in;
   logic [CW-1:0]        run_count_ff, run_count_in;
   logic [SW-1:0]        cur_ff, cur_in;
   logic [SW-1:0]        scan_ff, scan_in;
   logic [SLICE_W-1:0]   slice_count_ff, slice_count_in;
   logic                 slice_open_ff, slice_open_in;

   logic                 out_valid_ff;
   logic [TASK_ID_W-1:0] out_granted_ff, out_granted_in;
   logic [STATUS_W-1:0]  out_status_ff, out_status_in;
   logic                 out_done_ff;
   logic                 out_full_ff, out_full_in;

   logic [CW-1:0]        cur_next;
   logic [CW-1:0]        scan_next;
   logic [IW-1:0]        id_ext;
   logic [IW-1:0]        id_dec;
   logic                 id_ok;
   logic [IW-1:0]        grant_ext;
   logic [IW-1:0]        spawn_ext;
   logic [SLICE_W-1:0]   slice_inc;
   logic                 slice_close;

   assign cur_next  = CW'(cur_ff) + CW'(1);
   assign scan_next = CW'(scan_ff) + CW'(1);
   assign id_ext    = IW'(id_ff);
   assign id_dec    = id_ext - IW'(1);
   assign id_ok     = (id_ext != '0) && (id_ext <= IW'(task_count_ff));
   assign grant_ext = IW'(cur_ff) + IW'(1);
   assign spawn_ext = IW'(task_count_ff) + IW'(1);
   assign slice_inc = slice_count_ff + SLICE_W'(1);
   assign slice_close = (slice_inc >= time_slice_ff) || (slice_inc == '0);

   assign status.need_rotate = (opcode_type'(op_ff) == OP_ISSUE) && (run_count_ff != '0) &&
                               !(slice_open_ff && running_ff[cur_ff]);
   assign status.scan_hit    = running_ff[scan_ff] || (scan_ff == cur_ff);
   assign status.out_free    = !out_valid_ff || rsp_ready;

   always_comb begin
      running_in     = running_ff;
      task_count_in  = task_count_ff;
      run_count_in   = run_count_ff;
      cur_in         = cur_ff;
      scan_in        = scan_ff;
      slice_count_in = slice_count_ff;
      slice_open_in  = slice_open_ff;
      out_granted_in = '0;
      out_status_in  = STATUS_RUNNING;
      out_full_in    = 1'b0;

      if (cmd.scan_start) begin
         scan_in = (cur_next == task_count_ff) ? '0 : cur_next[SW-1:0];
      end

      if (cmd.scan_step) begin
         if (status.scan_hit) begin
            cur_in         = scan_ff;
            slice_open_in  = 1'b1;
            slice_count_in = '0;
         end else begin
            scan_in = (scan_next == task_count_ff) ? '0 : scan_next[SW-1:0];
         end
      end

      if (cmd.execute) begin
         unique case (opcode_type'(op_ff))
            OP_SPAWN: begin
               if (task_count_ff < CW'(MAX_TASKS)) begin
                  running_in[task_count_ff[SW-1:0]] = 1'b1;
                  task_count_in  = task_count_ff + CW'(1);
                  run_count_in   = run_count_ff + CW'(1);
                  out_granted_in = spawn_ext[TASK_ID_W-1:0];
               end else begin
                  out_full_in = 1'b1;
               end
            end
            OP_ISSUE: begin
               if (run_count_ff != '0) begin
                  out_granted_in = grant_ext[TASK_ID_W-1:0];
                  if (slice_close) begin
                     slice_open_in  = 1'b0;
                     slice_count_in = '0;
                  end else begin
                     slice_count_in = slice_inc;
                  end
               end
            end
            OP_FINISH: begin
               if (task_count_ff != '0) begin
                  if (running_ff[cur_ff]) begin
                     run_count_in = run_count_ff - CW'(1);
                  end
                  running_in[cur_ff] = 1'b0;
                  slice_open_in      = 1'b0;
                  slice_count_in     = '0;
               end
            end
            OP_QUERY: begin
               if (!id_ok) begin
                  out_status_in = STATUS_UNKNOWN;
               end else if (running_ff[id_dec[SW-1:0]]) begin
                  out_status_in = STATUS_RUNNING;
               end else begin
                  out_status_in = STATUS_COMPLETED;
               end
            end
            OP_RESTART: begin
               if (id_ok && !running_ff[id_dec[SW-1:0]]) begin
                  running_in[id_dec[SW-1:0]] = 1'b1;
                  run_count_in = run_count_ff + CW'(1);
               end
            end
            OP_CLEAR: begin
               running_in     = '0;
               task_count_in  = '0;
               run_count_in   = '0;
               cur_in         = '0;
               slice_count_in = '0;
               slice_open_in  = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_slice_ff  <= DEF_TIME_SLICE;
         running_ff     <= '0;
         task_count_ff  <= '0;
         run_count_ff   <= '0;
         cur_ff         <= '0;
         slice_count_ff <= '0;
         slice_open_ff  <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            time_slice_ff <= csr_write_data;
         end
         running_ff     <= running_in;
         task_count_ff  <= task_count_in;
         run_count_ff   <= run_count_in;
         cur_ff         <= cur_in;
         slice_count_ff <= slice_count_in;
         slice_open_ff  <= slice_open_in;
         if (cmd.execute) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      if (cmd.latch_req) begin
         op_ff <= req_opcode;
         id_ff <= req_task_id;
      end
      if (cmd.execute) begin
         out_granted_ff <= out_granted_in;
         out_status_ff  <= out_status_in;
         out_done_ff    <= (run_count_in == '0);
         out_full_ff    <= out_full_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_granted_id  = out_granted_ff;
   assign rsp_task_status = out_status_ff;
   assign rsp_all_done    = out_done_ff;
   assign rsp_table_full  = out_full_ff;

endmodule

>>> design/round_robin_time_slice_scheduler.sv
`timescale 1ns / 1ps

// Round-robin time-slice scheduler over MAX_TASKS task slots. Each request beat carries one
// opcode (spawn, issue, finish, query, restart, clear) and yields exactly one response beat.
// A request is registered in its accept cycle and then executed; an issue that must open a new
// slice first walks the task table one slot per cycle in the scan sequencer. The response sits
// in an output register, so a new request is accepted while an earlier response waits; it
// is executed once that register is free. csr_write_data sets the number of grants per slice
// (reset 500); the user must write it only while the block is idle, and the block itself does
// not enforce this.
module round_robin_time_slice_scheduler #(
   parameter int MAX_TASKS = rrts_pkg::DEF_MAX_TASKS
) (
   input  logic                         clock,
   input  logic                         reset,
   rrts_req_if.sink                     req_chan,
   rrts_rsp_if.source                   rsp_chan,
   input  logic                         csr_write_enable,
   input  logic [rrts_pkg::SLICE_W-1:0] csr_write_data
);
   import rrts_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   rrts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rrts_datapath #(
      .MAX_TASKS (MAX_TASKS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_opcode       (req_chan.opcode),
      .req_task_id      (req_chan.task_id),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_granted_id   (rsp_chan.granted_id),
      .rsp_task_status  (rsp_chan.task_status),
      .rsp_all_done     (rsp_chan.all_done),
      .rsp_table_full   (rsp_chan.table_full)
   );

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request accepted while another item is in flight");

   a_exec_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> rsp_chan.valid)
      else $error("executed item produced no response beat");

   a_exec_free: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |-> (status.out_free && !status.need_rotate))
      else $error("item executed over a pending response or before rotation");

   a_full_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.table_full) |->
         (rsp_chan.granted_id == '0 && rsp_chan.task_status == STATUS_RUNNING))
      else $error("full-table response carries stray fields");

endmodule
